[rtl/eor_pkg.sv]
// Shared types and constants for the edit offset remapper.
package eor_pkg;

	localparam int MaxEditsDefault = 64;
	localparam int DeltaW = 34;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_MAP    = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_OVERLAP = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] edit_start;
		logic [31:0] edit_end;
		logic [31:0] edit_length;
		logic [31:0] query_offset;
		logic        query_has_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] mapped_offset;
		logic [31:0] new_size;
	} out_item_t;

	// Classified command handed from front to back.
	typedef struct packed {
		op_t         op;
		logic [31:0] edit_start;
		logic [31:0] edit_end;
		logic [31:0] edit_length;
		logic [31:0] offset;
		logic        range_bad;
	} cmd_t;

	// Clamp a signed 35-bit value to unsigned 32 bits.
	function automatic logic [31:0] clamp_u32(input logic signed [DeltaW:0] v);
		logic [31:0] r;
		if (v[DeltaW])
			r = 32'd0;
		else if (v[DeltaW-1:32] != '0)
			r = 32'hFFFF_FFFF;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[rtl/edit_offset_remapper_top.sv]
// Top level of the edit offset remapper: front end, command queue, back end.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, in_data    | in
//  output  | out_valid, out_ready, out_data | out
//  config  | cfg_we, cfg_wdata              | in
//
// Clear and append are answered straight from the idle state; a map query scans the
// table entries in turn (memory read, then compare for each entry), then does the end
// check and gives the result, a sequential scan set by the single read port of the edit table.
// The front end keeps taking transfers into a two-entry queue meanwhile, while it has room.
// arst_n clears the count, running delta and last end; table contents stay
// undefined. The back end stalls while a result waits in the output register.
module edit_offset_remapper_top #(
	parameter int MAX_EDITS = eor_pkg::MaxEditsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  eor_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output eor_pkg::out_item_t  out_data
);

	logic [31:0]   original_size_q;
	logic          cmd_valid, cmd_ready;
	eor_pkg::cmd_t cmd_data;

	// Document size register; the user must write it only while idle (the block itself does not enforce this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			original_size_q <= '0;
		else if (cfg_we)
			original_size_q <= cfg_wdata;
	end

	eor_front u_front (
		.clk, .arst_n,
		.original_size (original_size_q),
		.in_valid, .in_ready, .in_data,
		.cmd_valid, .cmd_ready, .cmd_data
	);

	eor_back #(.MAX_EDITS(MAX_EDITS)) u_back (
		.clk, .arst_n,
		.original_size (original_size_q),
		.cmd_valid, .cmd_ready, .cmd_data,
		.out_valid, .out_ready, .out_data
	);

endmodule

[rtl/eor_front.sv]
// Front end: accepts items, resolves map offsets and range checks, fills a queue.
module eor_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         original_size,
	input  logic                in_valid,
	output logic                in_ready,
	input  eor_pkg::in_item_t   in_data,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output eor_pkg::cmd_t       cmd_data
);

	// Two-entry queue.
	eor_pkg::cmd_t mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	eor_pkg::cmd_t c;
	logic [31:0]   off;
	logic          push, pop;

	always_comb begin
		off = in_data.query_has_offset ? in_data.query_offset : original_size;
		if (off > original_size) off = original_size;
		c.op          = eor_pkg::op_t'(in_data.operation);
		c.edit_start  = in_data.edit_start;
		c.edit_end    = in_data.edit_end;
		c.edit_length = in_data.edit_length;
		c.offset      = off;
		c.range_bad   = (in_data.edit_start > in_data.edit_end) ||
		                (in_data.edit_end > original_size);
	end

	assign in_ready  = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/eor_back.sv]
// Back end: edit table, append logic and sequential map scan.
module eor_back #(
	parameter int MAX_EDITS = eor_pkg::MaxEditsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         original_size,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  eor_pkg::cmd_t       cmd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output eor_pkg::out_item_t  out_data
);

	localparam int IW = (MAX_EDITS > 1) ? $clog2(MAX_EDITS) : 1;
	localparam int CW = $clog2(MAX_EDITS + 1);
	localparam int DW = eor_pkg::DeltaW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EVAL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	// Table memory: one write port, one registered read port.
	logic [31:0]           m_start  [MAX_EDITS];
	logic [31:0]           m_end    [MAX_EDITS];
	logic [31:0]           m_len    [MAX_EDITS];
	logic signed [DW-1:0]  m_dbef   [MAX_EDITS];
	logic signed [DW-1:0]  m_daft   [MAX_EDITS];
	logic [31:0]           r_start_q, r_end_q, r_len_q;
	logic signed [DW-1:0]  r_dbef_q, r_daft_q;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [31:0]          last_end_q;
	logic signed [DW-1:0] rdelta_q;
	logic signed [DW-1:0] delta_q;
	eor_pkg::cmd_t        cmd_q;
	logic                 ov_q;
	eor_pkg::out_item_t   ob_q;

	logic                 wr_en, take;
	logic signed [DW+1:0] after_w;
	logic signed [DW-1:0] after_c;
	logic [31:0]          rel, cl;
	logic signed [DW:0]   inside_v, pass_v, size_v;
	eor_pkg::out_item_t   res;

	assign cmd_ready = state_q == S_IDLE && !ov_q;
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = ov_q;
	assign out_data  = ob_q;

	always_comb begin
		after_w = {{2{rdelta_q[DW-1]}}, rdelta_q} + $signed({4'd0, cmd_data.edit_length})
		        - $signed({4'd0, cmd_data.edit_end - cmd_data.edit_start});
		if (after_w > $signed({3'b000, {(DW-1){1'b1}}}))
			after_c = {1'b0, {(DW-1){1'b1}}};
		else if (after_w < $signed({3'b111, {(DW-1){1'b0}}}))
			after_c = {1'b1, {(DW-1){1'b0}}};
		else
			after_c = after_w[DW-1:0];
		wr_en = take && cmd_data.op == eor_pkg::OP_APPEND && !cmd_data.range_bad &&
		        cmd_data.edit_start >= last_end_q && count_q < CW'(MAX_EDITS);
		rel      = cmd_q.offset - r_start_q;
		cl       = (rel < r_len_q) ? rel : r_len_q;
		inside_v = $signed({3'd0, r_start_q}) + {r_dbef_q[DW-1], r_dbef_q}
		         + $signed({3'd0, cl});
		pass_v   = $signed({3'd0, cmd_q.offset}) + {delta_q[DW-1], delta_q};
		size_v   = $signed({3'd0, original_size}) + {rdelta_q[DW-1], rdelta_q};

		// Direct result for clear, append and unused codes.
		res = '0;
		res.new_size = eor_pkg::clamp_u32(size_v);
		case (cmd_data.op)
			eor_pkg::OP_CLEAR: res.new_size = original_size;
			eor_pkg::OP_APPEND: begin
				if (cmd_data.range_bad)
					res.status = eor_pkg::ST_RANGE;
				else if (cmd_data.edit_start < last_end_q)
					res.status = eor_pkg::ST_OVERLAP;
				else if (count_q >= CW'(MAX_EDITS))
					res.status = eor_pkg::ST_FULL;
				else
					res.new_size = eor_pkg::clamp_u32(
						$signed({3'd0, original_size}) + {after_c[DW-1], after_c});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			m_start[count_q[IW-1:0]] <= cmd_data.edit_start;
			m_end[count_q[IW-1:0]]   <= cmd_data.edit_end;
			m_len[count_q[IW-1:0]]   <= cmd_data.edit_length;
			m_dbef[count_q[IW-1:0]]  <= rdelta_q;
			m_daft[count_q[IW-1:0]]  <= after_c;
		end
		r_start_q <= m_start[idx_q[IW-1:0]];
		r_end_q   <= m_end[idx_q[IW-1:0]];
		r_len_q   <= m_len[idx_q[IW-1:0]];
		r_dbef_q  <= m_dbef[idx_q[IW-1:0]];
		r_daft_q  <= m_daft[idx_q[IW-1:0]];
		if (take) cmd_q <= cmd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			last_end_q <= '0;
			rdelta_q   <= '0;
			delta_q    <= '0;
			ov_q       <= 1'b0;
			ob_q       <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						case (cmd_data.op)
							eor_pkg::OP_CLEAR: begin
								count_q    <= '0;
								last_end_q <= '0;
								rdelta_q   <= '0;
								ob_q <= res;
								ov_q <= 1'b1;
							end
							eor_pkg::OP_APPEND: begin
								if (wr_en) begin
									count_q    <= count_q + 1'b1;
									last_end_q <= cmd_data.edit_end;
									rdelta_q   <= after_c;
								end
								ob_q <= res;
								ov_q <= 1'b1;
							end
							eor_pkg::OP_MAP: begin
								idx_q   <= '0;
								delta_q <= '0;
								state_q <= S_READ;
							end
							default: begin
								ob_q <= res;
								ov_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= (idx_q < count_q) ? S_EVAL : S_DONE;
				end
				S_EVAL: begin
					if (cmd_q.offset < r_start_q)
						state_q <= S_DONE;
					else if (cmd_q.offset < r_end_q) begin
						ob_q.status        <= eor_pkg::ST_OK;
						ob_q.mapped_offset <= eor_pkg::clamp_u32(inside_v);
						ob_q.new_size      <= eor_pkg::clamp_u32(size_v);
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						delta_q <= r_daft_q;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					ob_q.status        <= eor_pkg::ST_OK;
					ob_q.mapped_offset <= eor_pkg::clamp_u32(pass_v);
					ob_q.new_size      <= eor_pkg::clamp_u32(size_v);
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sim/tb_edit_offset_remapper_top.sv]
// Testbench for the edit offset remapper: random and directed edit tables, checked by scoreboard.
module tb_edit_offset_remapper_top;

	localparam int NumEdits = 64;
	localparam longint DeltaHi = 64'sd8589934591;
	localparam longint DeltaLo = -64'sd8589934592;
	localparam longint CycleLimit = 2000000;

	// Scoreboard: own copy of the edit table and the document size, plus the
	// queue of results still owed by the block.
	class remap_scoreboard;
		logic [31:0] doc_size;
		logic [31:0] ed_start[NumEdits];
		logic [31:0] ed_end[NumEdits];
		logic [31:0] ed_len[NumEdits];
		longint ed_dbefore[NumEdits];
		longint ed_dafter[NumEdits];
		int unsigned ed_count;
		logic [31:0] tail_end;
		longint size_delta;
		eor_pkg::out_item_t owed[$];
		int unsigned n_fail;
		int unsigned n_checked;
		int unsigned n_status[4];

		function new();
			doc_size = '0;
			ed_count = 0;
			tail_end = '0;
			size_delta = 0;
			n_fail = 0;
			n_checked = 0;
			foreach (n_status[i]) n_status[i] = 0;
		endfunction

		function logic [31:0] sat32(longint v);
			if (v < 0) return 32'd0;
			if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
			return v[31:0];
		endfunction

		function logic [31:0] translate(logic [31:0] off);
			longint shift;
			logic [31:0] rel;
			logic [31:0] cl;
			shift = 0;
			for (int i = 0; i < ed_count; i++) begin
				if (off < ed_start[i])
					break;
				if (off < ed_end[i]) begin
					rel = off - ed_start[i];
					cl = (rel < ed_len[i]) ? rel : ed_len[i];
					return sat32(longint'(ed_start[i]) + ed_dbefore[i] + longint'(cl));
				end
				shift = ed_dafter[i];
			end
			return sat32(longint'(off) + shift);
		endfunction

		// Note one accepted input transfer and queue its expected result.
		function void note_input(eor_pkg::in_item_t it);
			eor_pkg::out_item_t r;
			longint d;
			longint nxt;
			logic [31:0] off;
			r = '0;
			case (eor_pkg::op_t'(it.operation))
				eor_pkg::OP_CLEAR: begin
					ed_count = 0;
					tail_end = '0;
					size_delta = 0;
				end
				eor_pkg::OP_APPEND: begin
					if (it.edit_start > it.edit_end || it.edit_end > doc_size)
						r.status = eor_pkg::ST_RANGE;
					else if (it.edit_start < tail_end)
						r.status = eor_pkg::ST_OVERLAP;
					else if (ed_count >= NumEdits)
						r.status = eor_pkg::ST_FULL;
					else begin
						d = longint'(it.edit_length) - longint'(it.edit_end - it.edit_start);
						nxt = size_delta + d;
						if (nxt > DeltaHi) nxt = DeltaHi;
						if (nxt < DeltaLo) nxt = DeltaLo;
						ed_start[ed_count] = it.edit_start;
						ed_end[ed_count] = it.edit_end;
						ed_len[ed_count] = it.edit_length;
						ed_dbefore[ed_count] = size_delta;
						ed_dafter[ed_count] = nxt;
						ed_count++;
						size_delta = nxt;
						tail_end = it.edit_end;
					end
				end
				eor_pkg::OP_MAP: begin
					off = it.query_has_offset ? it.query_offset : doc_size;
					if (off > doc_size) off = doc_size;
					r.mapped_offset = translate(off);
				end
				default: ;
			endcase
			r.new_size = sat32(longint'(doc_size) + size_delta);
			owed = {owed, r};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch #%0d: %s got %h want %h", n_checked, what, got, want);
			n_fail++;
		endtask

		// Compare one accepted output transfer with the oldest expectation.
		task check_result(eor_pkg::out_item_t got);
			eor_pkg::out_item_t want;
			n_checked++;
			if (owed.size() == 0) begin
				report("unexpected result", got.mapped_offset, 32'd0);
				return;
			end
			want = owed.pop_front();
			n_status[want.status]++;
			if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
			if (got.mapped_offset !== want.mapped_offset)
				report("mapped_offset", got.mapped_offset, want.mapped_offset);
			if (got.new_size !== want.new_size) report("new_size", got.new_size, want.new_size);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	eor_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	eor_pkg::out_item_t out_data;

	remap_scoreboard sb = new();
	longint cycles = 0;
	bit calm = 1'b0;      // last part of the run: no idling on either side
	int hold_off = 0;     // long receiver stall requested by the stimulus

	always #5 clk = ~clk;

	edit_offset_remapper_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Watchdog.
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				n = hold_off;
				hold_off = 0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	// Offer one item and wait for its transfer; valid held, payload stable.
	// Valid stays high afterwards so the next item can follow without a gap.
	task automatic send(eor_pkg::in_item_t it);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		// A map can still be scanning nothing, but give the pipe time to settle.
		repeat (2 * NumEdits + 8) @(negedge clk);
	endtask

	task automatic set_size(logic [31:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.doc_size = v;
	endtask

	function automatic eor_pkg::in_item_t mk(eor_pkg::op_t op, logic [31:0] s, logic [31:0] e,
			logic [31:0] l, logic [31:0] q, logic h);
		eor_pkg::in_item_t it;
		it.operation = op;
		it.edit_start = s;
		it.edit_end = e;
		it.edit_length = l;
		it.query_offset = q;
		it.query_has_offset = h;
		return it;
	endfunction

	function automatic logic [31:0] rnd32();
		return {$urandom()} ;
	endfunction

	// Build an ordered table with some broken appends mixed in, then query it. Sizes are kept varied.
	task automatic table_round(int n_app, int n_map);
		logic [31:0] pos;
		logic [31:0] s;
		logic [31:0] e;
		logic [31:0] gap;
		logic [31:0] sz;
		sz = sb.doc_size;
		send(mk(eor_pkg::OP_CLEAR, rnd32(), rnd32(), rnd32(), rnd32(),
			1'($urandom_range(0, 1))));
		pos = 0;
		gap = (sz / (n_app + 1)) + 1;
		for (int i = 0; i < n_app; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				// broken append: bad range or overlap
				s = $urandom_range(0, 1) ? rnd32() : pos - 1;
				send(mk(eor_pkg::OP_APPEND, s, rnd32(), rnd32(), rnd32(),
					1'($urandom_range(0, 1))));
			end else begin
				s = pos + (gap == 0 ? 0 : rnd32() % gap);
				if (s > sz || s < pos) s = pos;
				e = s + (gap == 0 ? 0 : rnd32() % gap);
				if (e > sz || e < s) e = s;
				case ($urandom_range(0, 3))
					0: send(mk(eor_pkg::OP_APPEND, s, e, rnd32(), rnd32(), 1'b0));
					1: send(mk(eor_pkg::OP_APPEND, s, e, 32'd0, rnd32(), 1'b1));
					default: send(mk(eor_pkg::OP_APPEND, s, e, $urandom_range(0, 300), rnd32(),
						1'($urandom_range(0, 1))));
				endcase
				pos = e;
			end
			if ($urandom_range(0, 3) == 0)
				send(mk(eor_pkg::OP_MAP, rnd32(), rnd32(), rnd32(), rnd32() % (sz + 2), 1'b1));
		end
		for (int i = 0; i < n_map; i++) begin
			case ($urandom_range(0, 5))
				0: send(mk(eor_pkg::OP_MAP, rnd32(), rnd32(), rnd32(), rnd32(),
					1'($urandom_range(0, 1))));
				1: send(mk(eor_pkg::OP_NONE, rnd32(), rnd32(), rnd32(), rnd32(),
					1'($urandom_range(0, 1))));
				default: send(mk(eor_pkg::OP_MAP, rnd32(), rnd32(), rnd32(),
					(sz == 32'hFFFF_FFFF) ? rnd32() : rnd32() % (sz + 1), 1'b1));
			endcase
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, extremes, every operation and status.
		send(mk(eor_pkg::OP_MAP, '1, '1, '1, '1, 1'b1));
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, '0, 1'b0));
		send(mk(eor_pkg::OP_NONE, '1, '1, '1, '1, 1'b1));
		send(mk(eor_pkg::OP_APPEND, 32'd0, 32'd1, 32'd0, '0, 1'b0));   // end past size
		set_size(32'hFFFF_FFFF);
		send(mk(eor_pkg::OP_APPEND, 32'd5, 32'd4, 32'd1, '0, 1'b0));   // start after end
		send(mk(eor_pkg::OP_APPEND, 32'd0, 32'd0, 32'hFFFF_FFFF, '0, 1'b0));
		send(mk(eor_pkg::OP_APPEND, 32'd10, 32'd20, 32'hFFFF_FFFF, '0, 1'b0));
		send(mk(eor_pkg::OP_APPEND, 32'd15, 32'd30, 32'd1, '0, 1'b0)); // overlap
		send(mk(eor_pkg::OP_APPEND, 32'd30, 32'd30, 32'hFFFF_FFFF, '0, 1'b0)); // saturates
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'd12, 1'b1));           // inside, clamps high
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'hFFFF_FFFF, 1'b1));
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, '0, 1'b0));
		send(mk(eor_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b0));
		send(mk(eor_pkg::OP_APPEND, 32'd0, 32'hFFFF_FFFF, 32'd0, '0, 1'b0)); // below zero
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'd100, 1'b1));
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, '0, 1'b0));
		send(mk(eor_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b0));
		// Fill the table and overflow it.
		set_size(32'd1000);
		for (int i = 0; i < NumEdits + 1; i++)
			send(mk(eor_pkg::OP_APPEND, i * 10, i * 10 + 5, 32'd2, '0, 1'b0));
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'd999, 1'b1));
		set_size(32'd300);                                   // shrink with edits stored
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'd999, 1'b1));
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, 32'd0, 1'b0));

		// Long receiver hold-off while items keep coming.
		hold_off = 400;
		for (int i = 0; i < 10; i++)
			send(mk(eor_pkg::OP_MAP, '0, '0, '0, $urandom_range(0, 400), 1'b1));
		// Sender pauses until every result has come.
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);

		// Random part: phases over several document sizes.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: set_size($urandom_range(0, 2000));
				1: set_size(rnd32());
				2: set_size(32'hFFFF_FFFF);
				default: set_size($urandom_range(0, 20));
			endcase
			if (ph == 10) calm = 1'b1;
			for (int r = 0; r < 4; r++)
				table_round((r == 3 && ph % 3 == 0) ? NumEdits + 2 : $urandom_range(0, 12),
					$urandom_range(3, 8));
		end
		set_size('0);
		send(mk(eor_pkg::OP_MAP, '0, '0, '0, '1, 1'b1));

		drain();
		$display("checked %0d results: ok %0d, range %0d, overlap %0d, full %0d",
			sb.n_checked, sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
		$display("covered empty, full and saturated tables across %0d cycles", cycles);
		if (sb.n_fail == 0 && sb.owed.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
